// ===== hw/rtl/relative_move_motor_fsm_unit_macros.svh =====
// ----------------------------------------------------------------------------
// relative move motor fsm: assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef RELATIVE_MOVE_MOTOR_FSM_UNIT_MACROS_SVH
`define RELATIVE_MOVE_MOTOR_FSM_UNIT_MACROS_SVH

// same-cycle implication, off while reset is held
`define RMM_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rmm check failed");

// next-cycle implication, off while reset is held
`define RMM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rmm check failed");

// next-cycle implication that also watches reset itself
`define RMM_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("rmm check failed");

`endif

// ===== hw/rtl/rmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rmm_pkg
// widths, mode codes and constants of the relative move motor controller
// ----------------------------------------------------------------------------
package rmm_pkg;

    localparam int unsigned C_POS_W  = 16;
    localparam int unsigned C_MODE_W = 3;

    // positions wrap modulo this value
    localparam logic [C_POS_W:0]   C_MODULUS    = 17'd65535;
    localparam logic [C_POS_W-1:0] C_DIST_RESET = 16'd60000;
    localparam logic [C_POS_W-1:0] C_POS_ALL1   = 16'hFFFF;

    localparam logic [C_MODE_W-1:0] C_MODE_IDLE        = 3'd0;
    localparam logic [C_MODE_W-1:0] C_MODE_START_DOWN  = 3'd1;
    localparam logic [C_MODE_W-1:0] C_MODE_START_UP    = 3'd2;
    localparam logic [C_MODE_W-1:0] C_MODE_ESTOP       = 3'd3;
    localparam logic [C_MODE_W-1:0] C_MODE_UP_WRAP     = 3'd4;
    localparam logic [C_MODE_W-1:0] C_MODE_UP_NOWRAP   = 3'd5;
    localparam logic [C_MODE_W-1:0] C_MODE_DOWN_WRAP   = 3'd6;
    localparam logic [C_MODE_W-1:0] C_MODE_DOWN_NOWRAP = 3'd7;

endpackage

// ===== hw/rtl/rmm_req_if.sv =====
// ----------------------------------------------------------------------------
// rmm_req_if
// per-tick button and encoder request channel
// ----------------------------------------------------------------------------
interface rmm_req_if
    import rmm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               estop;
    logic               ack_button;
    logic               start_up;
    logic               start_down;
    logic [C_POS_W-1:0] position;

    modport source (
        output valid, estop, ack_button, start_up, start_down, position,
        input  ready
    );

    modport sink (
        input  valid, estop, ack_button, start_up, start_down, position,
        output ready
    );
endinterface

// ===== hw/rtl/rmm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rmm_rsp_if
// per-tick motor drive result channel
// ----------------------------------------------------------------------------
interface rmm_rsp_if
    import rmm_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                motor_right;
    logic                motor_left;
    logic                motor_enable;
    logic [C_MODE_W-1:0] mode_code;

    modport source (
        output valid, motor_right, motor_left, motor_enable, mode_code,
        input  ready
    );

    modport sink (
        input  valid, motor_right, motor_left, motor_enable, mode_code,
        output ready
    );
endinterface

// ===== hw/rtl/relative_move_motor_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// relative_move_motor_fsm_unit
// eight-mode relative move controller: buttons and encoder in, motor drive out
// ----------------------------------------------------------------------------
// One request per control tick, one result per request, in order. A request
// is captured in an input register; from there the mode machine, the
// modulo-65535 target arithmetic and the drive decode run as one pass into
// the result register. With the result side taking every cycle the unit
// accepts one request per clock. The input register frees up as soon as its
// request moves into the result register, so a new request is taken while a
// result is still waiting. Travel distance is written through i_cfg_wr_en/
// i_cfg_wr_data, by the user only while no request is in flight; the unit
// itself does not enforce this. The distance resets to 60000.
// ----------------------------------------------------------------------------
module relative_move_motor_fsm_unit
    import rmm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [C_POS_W-1:0] i_cfg_wr_data,
    rmm_req_if.sink            i_req,
    rmm_rsp_if.source          o_rsp
);

    typedef enum logic [C_MODE_W-1:0] {
        S_IDLE        = C_MODE_IDLE,
        S_START_DOWN  = C_MODE_START_DOWN,
        S_START_UP    = C_MODE_START_UP,
        S_ESTOP       = C_MODE_ESTOP,
        S_UP_WRAP     = C_MODE_UP_WRAP,
        S_UP_NOWRAP   = C_MODE_UP_NOWRAP,
        S_DOWN_WRAP   = C_MODE_DOWN_WRAP,
        S_DOWN_NOWRAP = C_MODE_DOWN_NOWRAP
    } t_state;

    // input register
    logic               r_s1_valid;
    logic               r_s1_estop;
    logic               r_s1_ack;
    logic               r_s1_up;
    logic               r_s1_down;
    logic [C_POS_W-1:0] r_s1_pos;

    // machine state and distance register
    t_state             r_mode;
    t_state             n_mode;
    logic [C_POS_W-1:0] r_start;
    logic [C_POS_W-1:0] r_target;
    logic [C_POS_W-1:0] n_target;
    logic [C_POS_W-1:0] r_distance;

    // result register
    logic                r_out_valid;
    logic                r_out_right;
    logic                r_out_left;
    logic                r_out_enable;
    logic [C_MODE_W-1:0] r_out_mode;
    logic                n_right;
    logic                n_left;

    logic               s2_adv;
    logic               in_take;
    logic [C_POS_W:0]   up_diff;
    logic [C_POS_W-1:0] up_tgt;
    logic [C_POS_W:0]   dn_sum;
    logic [C_POS_W:0]   dn_red;
    logic [C_POS_W-1:0] dn_tgt;

    assign s2_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s2_adv;
    assign in_take     = i_req.valid && i_req.ready;

    // upward target: start - distance, brought into 0..65534
    assign up_diff = {1'b0, r_s1_pos} - {1'b0, r_distance};
    always_comb begin
        if (up_diff[C_POS_W]) begin
            up_tgt = up_diff[C_POS_W-1:0] - 16'd1;
        end else if (up_diff[C_POS_W-1:0] == C_POS_ALL1) begin
            up_tgt = '0;
        end else begin
            up_tgt = up_diff[C_POS_W-1:0];
        end
    end

    // downward target: start + distance, brought into 0..65534
    assign dn_sum = {1'b0, r_s1_pos} + {1'b0, r_distance};
    assign dn_red = (dn_sum >= C_MODULUS) ? (dn_sum - C_MODULUS) : dn_sum;
    assign dn_tgt = (dn_red[C_POS_W-1:0] == C_POS_ALL1) ? '0 : dn_red[C_POS_W-1:0];

    always_comb begin
        n_mode = r_mode;
        if (r_mode == S_ESTOP) begin
            n_mode = (r_s1_ack && !r_s1_estop) ? S_IDLE : S_ESTOP;
        end else if (r_s1_estop) begin
            n_mode = S_ESTOP;
        end else begin
            case (r_mode)
                S_IDLE: begin
                    if (r_s1_up && !r_s1_down) begin
                        n_mode = S_START_UP;
                    end else if (!r_s1_up && r_s1_down) begin
                        n_mode = S_START_DOWN;
                    end
                end
                S_START_UP: begin
                    n_mode = (r_s1_pos >= r_target) ? S_UP_NOWRAP : S_UP_WRAP;
                end
                S_START_DOWN: begin
                    n_mode = (r_s1_pos > r_target) ? S_DOWN_WRAP : S_DOWN_NOWRAP;
                end
                S_UP_WRAP: begin
                    if (r_s1_pos < r_target && r_s1_pos > r_start) begin
                        n_mode = S_IDLE;
                    end else if (r_s1_up) begin
                        n_mode = S_START_UP;
                    end
                end
                S_UP_NOWRAP: begin
                    if (r_s1_pos < r_target || r_s1_pos > r_start) begin
                        n_mode = S_IDLE;
                    end else if (r_s1_up) begin
                        n_mode = S_START_UP;
                    end
                end
                S_DOWN_WRAP: begin
                    if (r_s1_pos > r_target && r_s1_pos < r_start) begin
                        n_mode = S_IDLE;
                    end else if (r_s1_down) begin
                        n_mode = S_START_DOWN;
                    end
                end
                S_DOWN_NOWRAP: begin
                    if (r_s1_pos > r_target || r_s1_pos < r_start) begin
                        n_mode = S_IDLE;
                    end else if (r_s1_down) begin
                        n_mode = S_START_DOWN;
                    end
                end
                default: begin
                    n_mode = S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        n_right  = 1'b0;
        n_left   = 1'b0;
        n_target = r_target;
        case (n_mode)
            S_START_UP: begin
                n_left   = 1'b1;
                n_target = up_tgt;
            end
            S_UP_WRAP, S_UP_NOWRAP: begin
                n_left = 1'b1;
            end
            S_START_DOWN: begin
                n_right  = 1'b1;
                n_target = dn_tgt;
            end
            S_DOWN_WRAP, S_DOWN_NOWRAP: begin
                n_right = 1'b1;
            end
            default: begin
                n_right = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= S_IDLE;
            r_start     <= '0;
            r_target    <= '0;
            r_distance  <= C_DIST_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_distance <= i_cfg_wr_data;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_mode   <= n_mode;
                r_target <= n_target;
                // start point latched on entry to either start mode
                if (n_mode == S_START_UP || n_mode == S_START_DOWN) begin
                    r_start <= r_s1_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_estop <= i_req.estop;
            r_s1_ack   <= i_req.ack_button;
            r_s1_up    <= i_req.start_up;
            r_s1_down  <= i_req.start_down;
            r_s1_pos   <= i_req.position;
        end
        if (s2_adv) begin
            r_out_right  <= n_right;
            r_out_left   <= n_left;
            r_out_enable <= n_right | n_left;
            r_out_mode   <= n_mode;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.motor_right  = r_out_right;
    assign o_rsp.motor_left   = r_out_left;
    assign o_rsp.motor_enable = r_out_enable;
    assign o_rsp.mode_code    = r_out_mode;

endmodule

// ===== hw/rtl/rmm_checker.sv =====
// ----------------------------------------------------------------------------
// rmm_checker
// port-level checks on the relative move motor controller
// ----------------------------------------------------------------------------
`include "relative_move_motor_fsm_unit_macros.svh"

module rmm_checker
    import rmm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_motor_right,
    input logic                i_motor_left,
    input logic                i_motor_enable,
    input logic [C_MODE_W-1:0] i_mode_code
);

    logic drive_up;
    logic drive_down;
    logic drive_ok;

    assign drive_up   = (i_mode_code == C_MODE_START_UP) ||
                        (i_mode_code == C_MODE_UP_WRAP) ||
                        (i_mode_code == C_MODE_UP_NOWRAP);
    assign drive_down = (i_mode_code == C_MODE_START_DOWN) ||
                        (i_mode_code == C_MODE_DOWN_WRAP) ||
                        (i_mode_code == C_MODE_DOWN_NOWRAP);
    assign drive_ok   = (i_motor_left == drive_up) && (i_motor_right == drive_down) &&
                        (i_motor_enable == (drive_up || drive_down));

    // nothing comes out in the cycle after reset
    `RMM_ASSERT_NEXT_ALWAYS(a_no_rsp_after_rst, i_clk, !i_rst_n, !i_out_valid)

    // a stalled result holds
    `RMM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_mode_code) && $stable(i_motor_enable))

    // drive bits agree with the reported mode
    `RMM_ASSERT_NOW(a_drive_match, i_clk, i_rst_n, i_out_valid, drive_ok)

endmodule

bind relative_move_motor_fsm_unit rmm_checker u_rmm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_motor_right  (o_rsp.motor_right),
    .i_motor_left   (o_rsp.motor_left),
    .i_motor_enable (o_rsp.motor_enable),
    .i_mode_code    (o_rsp.mode_code)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// relative move motor controller: button and encoder requests with random
// move sequences, emergency stops and noise under random idling on both
// channels, each result checked against a mode machine predictor
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rmm_pkg::*;

    localparam int unsigned C_CYCLE_LIMIT = 400000;
    localparam int unsigned C_PHASE_ITEMS = 305;
    localparam int unsigned C_NUM_PHASES  = 6;

    typedef struct packed {
        logic               estop;
        logic               ack_button;
        logic               start_up;
        logic               start_down;
        logic [C_POS_W-1:0] position;
    } t_button_req;

    typedef struct packed {
        logic                motor_right;
        logic                motor_left;
        logic                motor_enable;
        logic [C_MODE_W-1:0] mode_code;
    } t_drive_rsp;

    class motor_drive_scoreboard;
        logic [C_POS_W-1:0]  distance;
        logic [C_MODE_W-1:0] mode;
        logic [C_POS_W-1:0]  move_start;
        logic [C_POS_W-1:0]  move_target;
        t_drive_rsp          expected_drive[$];
        int unsigned         errors;

        function new();
            distance    = C_DIST_RESET;
            mode        = C_MODE_IDLE;
            move_start  = '0;
            move_target = '0;
            errors      = 0;
        endfunction

        function int unsigned pending();
            return expected_drive.size();
        endfunction

        function logic [C_MODE_W-1:0] next_mode(t_button_req r);
            logic [C_MODE_W-1:0] nxt;
            logic [C_POS_W-1:0]  pos;
            nxt = mode;
            pos = r.position;
            if (mode == C_MODE_ESTOP) begin
                nxt = (r.ack_button && !r.estop) ? C_MODE_IDLE : C_MODE_ESTOP;
            end else if (r.estop) begin
                nxt = C_MODE_ESTOP;
            end else begin
                case (mode)
                    C_MODE_IDLE: begin
                        if (r.start_up && !r.start_down)
                            nxt = C_MODE_START_UP;
                        else if (!r.start_up && r.start_down)
                            nxt = C_MODE_START_DOWN;
                    end
                    C_MODE_START_UP: begin
                        nxt = (pos >= move_target) ? C_MODE_UP_NOWRAP : C_MODE_UP_WRAP;
                    end
                    C_MODE_START_DOWN: begin
                        nxt = (pos > move_target) ? C_MODE_DOWN_WRAP : C_MODE_DOWN_NOWRAP;
                    end
                    C_MODE_UP_WRAP: begin
                        if (pos < move_target && pos > move_start)
                            nxt = C_MODE_IDLE;
                        else if (r.start_up)
                            nxt = C_MODE_START_UP;
                    end
                    C_MODE_UP_NOWRAP: begin
                        if (pos < move_target || pos > move_start)
                            nxt = C_MODE_IDLE;
                        else if (r.start_up)
                            nxt = C_MODE_START_UP;
                    end
                    C_MODE_DOWN_WRAP: begin
                        if (pos > move_target && pos < move_start)
                            nxt = C_MODE_IDLE;
                        else if (r.start_down)
                            nxt = C_MODE_START_DOWN;
                    end
                    default: begin
                        if (pos > move_target || pos < move_start)
                            nxt = C_MODE_IDLE;
                        else if (r.start_down)
                            nxt = C_MODE_START_DOWN;
                    end
                endcase
            end
            return nxt;
        endfunction

        function void note_request(t_button_req r);
            t_drive_rsp d;
            int         wrapped;
            mode = next_mode(r);
            // target is latched on every tick spent in a start mode
            if (mode == C_MODE_START_UP) begin
                wrapped = (int'(r.position) - int'(distance)) % int'(C_MODULUS);
                if (wrapped < 0)
                    wrapped += int'(C_MODULUS);
                move_start  = r.position;
                move_target = wrapped[C_POS_W-1:0];
            end else if (mode == C_MODE_START_DOWN) begin
                wrapped = (int'(r.position) + int'(distance)) % int'(C_MODULUS);
                move_start  = r.position;
                move_target = wrapped[C_POS_W-1:0];
            end
            d = '0;
            case (mode)
                C_MODE_START_UP, C_MODE_UP_WRAP, C_MODE_UP_NOWRAP: begin
                    d.motor_left   = 1'b1;
                    d.motor_enable = 1'b1;
                end
                C_MODE_START_DOWN, C_MODE_DOWN_WRAP, C_MODE_DOWN_NOWRAP: begin
                    d.motor_right  = 1'b1;
                    d.motor_enable = 1'b1;
                end
                default: ;
            endcase
            d.mode_code = mode;
            expected_drive.push_back(d);
        endfunction

        function void compare_field(string field, logic [C_MODE_W-1:0] want,
                                    logic [C_MODE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_drive_rsp got);
            t_drive_rsp want;
            if (expected_drive.size() == 0) begin
                $error("motor drive result with no request outstanding");
                errors++;
                return;
            end
            want = expected_drive.pop_front();
            compare_field("motor_right", C_MODE_W'(want.motor_right),
                          C_MODE_W'(got.motor_right));
            compare_field("motor_left", C_MODE_W'(want.motor_left),
                          C_MODE_W'(got.motor_left));
            compare_field("motor_enable", C_MODE_W'(want.motor_enable),
                          C_MODE_W'(got.motor_enable));
            compare_field("mode_code", want.mode_code, got.mode_code);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [C_POS_W-1:0] cfg_wr_data;
    int unsigned        tx_idle_pct = 0;
    int unsigned        rx_idle_pct = 0;
    int unsigned        cycles = 0;
    int unsigned        requests_sent = 0;

    motor_drive_scoreboard drive_model;

    rmm_req_if req_ch();
    rmm_rsp_if rsp_ch();

    relative_move_motor_fsm_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == C_CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            drive_model.check_result('{rsp_ch.motor_right, rsp_ch.motor_left,
                                       rsp_ch.motor_enable, rsp_ch.mode_code});
    end

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [C_POS_W-1:0] any_pos();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_request(input t_button_req r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.estop      <= r.estop;
        req_ch.ack_button <= r.ack_button;
        req_ch.start_up   <= r.start_up;
        req_ch.start_down <= r.start_down;
        req_ch.position   <= r.position;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        drive_model.note_request(r);
        requests_sent++;
    endtask

    task automatic send_buttons(input bit stop, input bit ack, input bit up, input bit down,
                                input logic [C_POS_W-1:0] pos);
        t_button_req r;
        r = '{stop, ack, up, down, pos};
        send_request(r);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (drive_model.pending() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_distance(input logic [C_POS_W-1:0] new_distance);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= new_distance;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        drive_model.distance = new_distance;
    endtask

    task automatic release_estop();
        int unsigned n;
        repeat ($urandom_range(0, 3))
            send_buttons(1'b1, coin(), coin(), coin(), any_pos());
        n = 0;
        while (drive_model.mode == C_MODE_ESTOP && n < 6) begin
            send_buttons($urandom_range(0, 3) == 0, coin(), coin(), coin(), any_pos());
            n++;
        end
        if (drive_model.mode == C_MODE_ESTOP)
            send_buttons(1'b0, 1'b1, coin(), coin(), any_pos());
    endtask

    // one start press, then the encoder walks in the travel direction
    task automatic run_move();
        bit                 go_up;
        int unsigned        step_max;
        int unsigned        ticks;
        int unsigned        pick;
        logic [C_POS_W-1:0] pos;
        go_up    = coin();
        step_max = drive_model.distance / 6 + 1;
        pick     = $urandom_range(0, 15);
        pos      = (pick == 0) ? '0 : (pick == 1) ? C_POS_ALL1 : any_pos();
        send_buttons(1'b0, $urandom_range(0, 3) == 0, go_up, !go_up, pos);
        ticks = 0;
        while (drive_model.mode != C_MODE_IDLE && drive_model.mode != C_MODE_ESTOP
               && ticks < 40) begin
            if (go_up)
                pos = pos - 16'($urandom_range(0, step_max));
            else
                pos = pos + 16'($urandom_range(0, step_max));
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_buttons(1'b0, 1'b0, go_up, !go_up, pos);
            else if (pick < 12)
                send_buttons(1'b0, 1'b0, !go_up, go_up, pos);
            else if (pick < 15)
                send_buttons(1'b0, coin(), 1'b1, 1'b1, pos);
            else if (pick < 18)
                send_buttons(1'b1, coin(), coin(), coin(), pos);
            else
                send_buttons(1'b0, $urandom_range(0, 3) == 0, 1'b0, 1'b0, pos);
            ticks++;
        end
        if (drive_model.mode == C_MODE_ESTOP)
            release_estop();
    endtask

    task automatic run_phase(input int unsigned count);
        int unsigned last;
        int unsigned pick;
        last = requests_sent + count;
        while (requests_sent < last) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                run_move();
            end else if (pick < 82) begin
                send_buttons(1'b1, coin(), coin(), coin(), any_pos());
                release_estop();
            end else begin
                send_buttons($urandom_range(0, 7) == 0, coin(), coin(), coin(), any_pos());
            end
            // hold off until the pipeline is empty now and then
            if ($urandom_range(0, 149) == 0)
                wait_drained();
        end
    endtask

    initial begin
        logic [C_POS_W-1:0] phase_distance [C_NUM_PHASES];
        drive_model = new();
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.estop      <= 1'b0;
        req_ch.ack_button <= 1'b0;
        req_ch.start_up   <= 1'b0;
        req_ch.start_down <= 1'b0;
        req_ch.position   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset distance
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b1, 16'd1234);      // both starts ignored
        send_buttons(1'b0, 1'b0, 1'b0, 1'b1, C_POS_ALL1);
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, C_POS_ALL1);
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd100);       // opposite button ignored
        send_buttons(1'b0, 1'b0, 1'b1, 1'b1, 16'd200);       // restart down
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, 16'd300);
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, 16'd60201);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, 16'd0);
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, 16'd0);
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, C_POS_ALL1);
        send_buttons(1'b1, 1'b0, 1'b0, 1'b0, C_POS_ALL1);
        send_buttons(1'b1, 1'b1, 1'b0, 1'b0, C_POS_ALL1);    // ack while stop held
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, 16'd5);
        send_buttons(1'b0, 1'b1, 1'b0, 1'b0, 16'd5);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b0, C_POS_ALL1);
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, C_POS_ALL1);
        send_buttons(1'b0, 1'b0, 1'b1, 1'b1, 16'd30000);     // restart up
        send_buttons(1'b0, 1'b0, 1'b0, 1'b0, 16'd29000);
        send_buttons(1'b1, 1'b1, 1'b1, 1'b1, 16'd29000);
        send_buttons(1'b0, 1'b1, 1'b1, 1'b0, 16'd29000);
        send_buttons(1'b0, 1'b0, 1'b0, 1'b1, 16'd5000);
        send_buttons(1'b1, 1'b0, 1'b0, 1'b0, 16'd5000);
        send_buttons(1'b0, 1'b1, 1'b0, 1'b0, 16'd5000);

        phase_distance = '{C_POS_ALL1, 16'd0, 16'd65534, 16'($urandom_range(1, 300)),
                           16'($urandom_range(0, 65534)), C_DIST_RESET};
        for (int unsigned phase = 0; phase < C_NUM_PHASES; phase++) begin
            tx_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 48 : 0;
            rx_idle_pct = (phase < 2) ? 48 : (phase < 4) ? 20 : 0;
            write_distance(phase_distance[phase]);
            run_phase(C_PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (drive_model.errors == 0 && drive_model.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rmm_pkg.sv
hw/rtl/rmm_req_if.sv
hw/rtl/rmm_rsp_if.sv
hw/rtl/relative_move_motor_fsm_unit.sv
hw/rtl/rmm_checker.sv
bench/testbench.sv
